[sv/hslr_pkg.sv]
// Shared types and constants for the HSL hue rotation pixel block.
// No dependencies.
package hslr_pkg;

   localparam int CHAN_W     = 8;
   localparam int HUE_STEP_W = 16;

   typedef logic [CHAN_W-1:0]     chan_type;
   typedef logic [HUE_STEP_W-1:0] hue_step_type;

   localparam hue_step_type HUE_STEP_RESET = 16'd655;

endpackage

[sv/hslr_req_if.sv]
// Input pixel channel: valid/ready handshake with RGB payload.
// Depends on hslr_pkg.
interface hslr_req_if;
   logic               valid;
   logic               ready;
   hslr_pkg::chan_type in_red;
   hslr_pkg::chan_type in_green;
   hslr_pkg::chan_type in_blue;

   modport source (output valid, in_red, in_green, in_blue, input ready);
   modport sink   (input valid, in_red, in_green, in_blue, output ready);
endinterface

[sv/hslr_rsp_if.sv]
// Result pixel channel: valid/ready handshake with RGB payload.
// Depends on hslr_pkg.
interface hslr_rsp_if;
   logic               valid;
   logic               ready;
   hslr_pkg::chan_type out_red;
   hslr_pkg::chan_type out_green;
   hslr_pkg::chan_type out_blue;

   modport source (output valid, out_red, out_green, out_blue, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

[sv/hslr_div.sv]
// Pipelined restoring divider: quo = floor(num * 2^FB / den) for num <= den.
// One quotient bit per stage, FB+1 stages. No dependencies.
module hslr_div #(
   parameter int FB    = 16,
   parameter int DEN_W = 11
) (
   input  logic             clock,
   input  logic             en,
   input  logic [DEN_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [FB:0]      quo
);
   logic [DEN_W-1:0] rem_ff [0:FB];
   logic [DEN_W-1:0] den_ff [0:FB];
   logic [FB:0]      quo_ff [0:FB];
   logic [DEN_W-1:0] rem_in [0:FB];
   logic [FB:0]      quo_in [0:FB];

   assign rem_in[0] = (num >= den) ? num - den : num;
   assign quo_in[0] = (num >= den) ? (FB+1)'(1) : '0;

   for (genvar k = 1; k <= FB; k++) begin : g_step
      logic [DEN_W:0] shl;
      logic           ge;
      assign shl = {rem_ff[k-1], 1'b0};
      assign ge  = shl >= {1'b0, den_ff[k-1]};
      assign rem_in[k] = ge ? DEN_W'(shl - {1'b0, den_ff[k-1]}) : DEN_W'(shl);
      assign quo_in[k] = {quo_ff[k-1][FB-1:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rem_in[0];
         quo_ff[0] <= quo_in[0];
         den_ff[0] <= den;
         for (int k = 1; k <= FB; k++) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
            den_ff[k] <= den_ff[k-1];
         end
      end
   end

   assign quo = quo_ff[FB];
endmodule

[sv/hsl_hue_rotate_pixel.sv]
// Hue rotation of 8-bit RGB pixels through fixed-point HSL.
// Depends on hslr_pkg, hslr_req_if, hslr_rsp_if, hslr_div.
//
// Usage:
//   req_chan carries one RGB pixel per transfer, rsp_chan one rotated pixel
//   per transfer, in the same order. csr_wr_en/csr_wr_data write hue_step
//   (1/65536 turn units); write only while no pixel is in flight.
// Stages: stage 1, the divider stages, then stages A, B, C and D.
//   Saturation and hue run through pipelined restoring dividers, one
//   quotient bit per stage, and set the depth of the pipeline;
//   lightness is a reciprocal multiply delayed to match.
// Throughput: one pixel per cycle, sustained unless a stall holds the pipeline.
// Reset: clears all valid bits and loads hue_step with 655.
// Stall: when rsp_chan.ready is low with a result waiting, the whole
//   pipeline holds and req_chan.ready drops, so a stall drops and repeats
//   nothing.
module hsl_hue_rotate_pixel #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   hslr_req_if.sink                       req_chan,
   hslr_rsp_if.source                     rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [hslr_pkg::HUE_STEP_W-1:0] csr_wr_data
);
   import hslr_pkg::*;

   localparam int FB    = FRACTION_BITS;
   localparam int DEN_W = 11;
   localparam int NST   = FB + 6;
   localparam int V_W   = FB + 1;
   localparam int Q_W   = FB + 2;
   localparam logic [FB-1:0] THIRD = FB'((64'd1 << FB) / 3);
   localparam logic [V_W-1:0] UNIT = V_W'(64'd1 << FB);
   localparam int L_SH  = 20;
   localparam int L_RW  = FB + 12;
   localparam logic [L_RW-1:0] L_RECIP =
      L_RW'(((64'd1 << (FB + L_SH)) + 64'd509) / 64'd510);

   localparam logic [1:0] SEG_UP   = 2'd0;
   localparam logic [1:0] SEG_HIGH = 2'd1;
   localparam logic [1:0] SEG_DOWN = 2'd2;
   localparam logic [1:0] SEG_LOW  = 2'd3;

   logic              adv;
   logic [NST-1:0]    vld_ff;
   hue_step_type      hue_step_ff;

   assign adv            = !vld_ff[NST-1] || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign rsp_chan.valid = vld_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         hue_step_ff <= HUE_STEP_RESET;
      end else begin
         if (adv) vld_ff <= {vld_ff[NST-2:0], req_chan.valid};
         if (csr_wr_en) hue_step_ff <= csr_wr_data;
      end
   end

   // stage 1: max/min, numerators and denominators
   logic [7:0]       r, g, b, mx, mn, d;
   logic [8:0]       sum;
   logic [DEN_W-1:0] n_in, d6;
   logic [DEN_W-1:0] l_num_ff, s_num_ff, s_den_ff, h_num_ff, h_den_ff;
   logic             grey_ff;

   always_comb begin
      r  = req_chan.in_red;
      g  = req_chan.in_green;
      b  = req_chan.in_blue;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d   = mx - mn;
      sum = {1'b0, mx} + {1'b0, mn};
      d6  = DEN_W'(d) * DEN_W'(6);
      if (mx == r) begin
         if (g >= b) n_in = DEN_W'(g - b);
         else        n_in = d6 - DEN_W'(b - g);
      end else if (mx == g) begin
         n_in = (DEN_W'(d) << 1) + DEN_W'(b) - DEN_W'(r);
      end else begin
         n_in = (DEN_W'(d) << 2) + DEN_W'(r) - DEN_W'(g);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         l_num_ff <= DEN_W'(sum);
         s_num_ff <= DEN_W'(d);
         s_den_ff <= (sum > 9'd255) ? DEN_W'(10'd510 - {1'b0, sum}) : DEN_W'(sum);
         h_num_ff <= n_in;
         h_den_ff <= d6;
         grey_ff  <= (d == 8'd0);
      end
   end

   // division stages; lightness is sum * 2^FB / 510 by reciprocal
   logic [FB:0]           l_quo, s_quo, h_quo;
   logic                  grey_dly_ff [0:FB];
   logic [DEN_W+L_RW-1:0] l_prod;
   logic [V_W-1:0]        l_dly_ff [0:FB];

   assign l_prod = (DEN_W+L_RW)'(l_num_ff) * (DEN_W+L_RW)'(L_RECIP);
   assign l_quo  = l_dly_ff[FB];

   hslr_div #(.FB(FB), .DEN_W(DEN_W)) u_div_s (
      .clock(clock), .en(adv), .num(s_num_ff), .den(s_den_ff), .quo(s_quo));
   hslr_div #(.FB(FB), .DEN_W(DEN_W)) u_div_h (
      .clock(clock), .en(adv), .num(h_num_ff), .den(h_den_ff), .quo(h_quo));

   always_ff @(posedge clock) begin
      if (adv) begin
         grey_dly_ff[0] <= grey_ff;
         l_dly_ff[0]    <= V_W'(l_prod >> L_SH);
         for (int k = 1; k <= FB; k++) begin
            grey_dly_ff[k] <= grey_dly_ff[k-1];
            l_dly_ff[k]    <= l_dly_ff[k-1];
         end
      end
   end

   // stage A: hue step, l*s
   logic [HUE_STEP_W+FB-1:0] step_wide;
   logic [FB-1:0]            step;
   logic [FB-1:0]            a_h_ff;
   logic [V_W-1:0]           a_l_ff, a_s_ff;
   logic [2*V_W-1:0]         a_m_ff;
   logic                     a_flat_ff;

   assign step_wide = {hue_step_ff, {FB{1'b0}}};
   assign step      = step_wide[HUE_STEP_W+FB-1:HUE_STEP_W];

   always_ff @(posedge clock) begin
      if (adv) begin
         a_h_ff    <= h_quo[FB-1:0] + step;
         a_l_ff    <= l_quo;
         a_s_ff    <= s_quo;
         a_m_ff    <= (2*V_W)'(l_quo) * (2*V_W)'(s_quo);
         a_flat_ff <= grey_dly_ff[FB] || (s_quo == '0);
      end
   end

   // stage B: q, p, channel hues
   logic [Q_W-1:0] m_hi, q_in;
   logic [Q_W:0]   p_wide;
   logic [Q_W-1:0] b_q_ff, b_p_ff;
   logic [V_W-1:0] b_l_ff;
   logic [FB-1:0]  b_t_ff [0:2];
   logic           b_flat_ff;

   always_comb begin
      m_hi = a_m_ff[2*V_W-1:FB];
      if ({a_l_ff, 1'b0} < {1'b0, UNIT}) q_in = Q_W'(a_l_ff) + m_hi;
      else q_in = Q_W'(a_l_ff) + Q_W'(a_s_ff) - m_hi;
      p_wide = {(Q_W+1-V_W)'(0), a_l_ff} + {(Q_W+1-V_W)'(0), a_l_ff} - {1'b0, q_in};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_q_ff    <= q_in;
         b_p_ff    <= p_wide[Q_W] ? '0 : p_wide[Q_W-1:0];
         b_l_ff    <= a_l_ff;
         b_t_ff[0] <= a_h_ff + THIRD;
         b_t_ff[1] <= a_h_ff;
         b_t_ff[2] <= a_h_ff - THIRD;
         b_flat_ff <= a_flat_ff;
      end
   end

   // stage C: segment select and ramp product
   localparam int T_W = FB + 3;
   logic [Q_W-1:0]     diff;
   logic [T_W-1:0]     t6 [0:2];
   logic [V_W-1:0]     fac [0:2];
   logic [1:0]         seg [0:2];
   logic [Q_W+V_W-1:0] c_prod_ff [0:2];
   logic [1:0]         c_seg_ff [0:2];
   logic [Q_W-1:0]     c_q_ff, c_p_ff;
   logic [V_W-1:0]     c_l_ff;
   logic               c_flat_ff;

   assign diff = b_q_ff - b_p_ff;

   for (genvar c = 0; c < 3; c++) begin : g_seg
      always_comb begin
         t6[c] = T_W'(b_t_ff[c]) * T_W'(6);
         if (t6[c] < T_W'(UNIT)) begin
            seg[c] = SEG_UP;
            fac[c] = V_W'(t6[c]);
         end else if ({1'b0, b_t_ff[c], 1'b0} < {1'b0, UNIT}) begin
            seg[c] = SEG_HIGH;
            fac[c] = '0;
         end else if (T_W'(b_t_ff[c]) * T_W'(3) < (T_W'(UNIT) << 1)) begin
            seg[c] = SEG_DOWN;
            fac[c] = V_W'((T_W'(UNIT) << 2) - t6[c]);
         end else begin
            seg[c] = SEG_LOW;
            fac[c] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            c_prod_ff[c] <= (Q_W+V_W)'(diff) * (Q_W+V_W)'(fac[c]);
            c_seg_ff[c]  <= seg[c];
         end
         c_q_ff    <= b_q_ff;
         c_p_ff    <= b_p_ff;
         c_l_ff    <= b_l_ff;
         c_flat_ff <= b_flat_ff;
      end
   end

   // stage D: channel value, scale to byte
   logic [Q_W:0]    v_raw [0:2];
   logic [V_W-1:0]  v [0:2];
   logic [V_W+7:0]  scaled [0:2];
   logic [8:0]      byte_raw [0:2];
   chan_type        d_out_ff [0:2];

   for (genvar c = 0; c < 3; c++) begin : g_out
      always_comb begin
         case (c_seg_ff[c])
            SEG_UP, SEG_DOWN:
               v_raw[c] = {1'b0, c_p_ff} + (Q_W+1)'(c_prod_ff[c] >> FB);
            SEG_HIGH: v_raw[c] = {1'b0, c_q_ff};
            default:  v_raw[c] = {1'b0, c_p_ff};
         endcase
         if (c_flat_ff) v[c] = c_l_ff;
         else if (v_raw[c] > (Q_W+1)'(UNIT)) v[c] = UNIT;
         else v[c] = V_W'(v_raw[c]);
         scaled[c]   = ((V_W+8)'(v[c]) << 8) - (V_W+8)'(v[c]);
         byte_raw[c] = 9'(scaled[c] >> FB);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++)
            d_out_ff[c] <= (byte_raw[c] > 9'd255) ? 8'd255 : byte_raw[c][7:0];
      end
   end

   assign rsp_chan.out_red   = d_out_ff[0];
   assign rsp_chan.out_green = d_out_ff[1];
   assign rsp_chan.out_blue  = d_out_ff[2];
endmodule
